// ===== hdl/dpf_pkg.sv =====
// Shared types and constants of the detection persistence filter.
package dpf_pkg;

   localparam int COORD_BITS         = 12;
   localparam int COLOR_BITS         = 3;
   localparam int INDEX_BITS         = 4;
   localparam int LIMIT_BITS         = 12;
   localparam int MAX_RESULTS        = 16;
   localparam int DEF_MAX_PER_FRAME  = 16;
   localparam int DEF_HISTORY_FRAMES = 3;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd80;

   localparam logic OP_DETECT    = 1'b0;
   localparam logic OP_FRAME_END = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic [COLOR_BITS-1:0] color_class;
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
   } req_type;

   typedef struct packed {
      logic                  valid_res;
      logic [INDEX_BITS-1:0] stable_index;
      logic [COLOR_BITS-1:0] out_color;
      logic [COORD_BITS-1:0] out_x;
      logic [COORD_BITS-1:0] out_y;
      logic                  frame_overflow;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] color;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } entry_type;

   // A candidate detection travelling down the row of frame cells.
   typedef struct packed {
      logic      valid;
      logic      ok;
      entry_type entry;
   } cand_type;

   typedef struct packed {
      logic is_cur;
      logic wr_en;
      logic clr;
      logic shift;
   } cell_ctl_type;

endpackage

// ===== hdl/dpf_cell.sv =====
// One frame cell: a frame's detections, and a scan of them against a passing candidate.
module dpf_cell #(
   parameter int MAX_PER_FRAME = dpf_pkg::DEF_MAX_PER_FRAME
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dpf_pkg::cell_ctl_type                ctl,
   input  dpf_pkg::entry_type                   wr_data,
   input  logic [$clog2(MAX_PER_FRAME+4)-1:0]   phase_t,
   input  logic [((MAX_PER_FRAME > 1) ? $clog2(MAX_PER_FRAME) : 1)-1:0] rd_addr,
   input  logic [2*dpf_pkg::LIMIT_BITS-1:0]     lim2,
   input  dpf_pkg::cand_type                    cand_in,
   output dpf_pkg::cand_type                    cand_out,
   output dpf_pkg::entry_type                   rd_data,
   output logic [$clog2(MAX_PER_FRAME+1)-1:0]   count
);

   localparam int AW = (MAX_PER_FRAME > 1) ? $clog2(MAX_PER_FRAME) : 1;
   localparam int CW = $clog2(MAX_PER_FRAME + 1);
   localparam int TW = $clog2(MAX_PER_FRAME + 4);
   localparam int CB = dpf_pkg::COORD_BITS;

   dpf_pkg::entry_type mem [0:MAX_PER_FRAME-1];
   dpf_pkg::entry_type rd_ff;
   dpf_pkg::cand_type  cand_ff;
   logic [CW-1:0]      count_ff;
   logic               found_ff;
   logic               rv_ff, eq_ff, sqv_ff;
   logic [CB-1:0]      dx_ff, dy_ff;
   logic [2*CB-1:0]    dx2_ff, dy2_ff;
   logic [AW-1:0]      addr;
   logic               scan_valid;
   logic               full;
   logic [CB-1:0]      dx_in, dy_in;

   // The cell of the current frame lends its read port to the candidate feeder.
   assign addr       = ctl.is_cur ? rd_addr : phase_t[AW-1:0];
   assign scan_valid = !ctl.is_cur && (phase_t < TW'(count_ff));
   assign full       = (count_ff == CW'(MAX_PER_FRAME));

   assign dx_in = (rd_ff.x > cand_ff.entry.x) ? rd_ff.x - cand_ff.entry.x
                                              : cand_ff.entry.x - rd_ff.x;
   assign dy_in = (rd_ff.y > cand_ff.entry.y) ? rd_ff.y - cand_ff.entry.y
                                              : cand_ff.entry.y - rd_ff.y;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && !full) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      rd_ff  <= mem[addr];
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dx2_ff <= dx_ff * dx_ff;
      dy2_ff <= dy_ff * dy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         found_ff      <= 1'b0;
         rv_ff         <= 1'b0;
         eq_ff         <= 1'b0;
         sqv_ff        <= 1'b0;
         cand_ff.valid <= 1'b0;
      end else begin
         rv_ff  <= scan_valid;
         eq_ff  <= rv_ff && (rd_ff.color == cand_ff.entry.color);
         sqv_ff <= eq_ff;
         if (ctl.clr) begin
            count_ff <= '0;
         end else if (ctl.wr_en && !full) begin
            count_ff <= count_ff + 1'b1;
         end
         if (ctl.shift) begin
            cand_ff  <= cand_in;
            found_ff <= 1'b0;
         end else if (sqv_ff && ({1'b0, dx2_ff} + {1'b0, dy2_ff} <= {1'b0, lim2})) begin
            found_ff <= 1'b1;
         end
      end
   end

   assign cand_out.valid = cand_ff.valid;
   assign cand_out.ok    = cand_ff.ok && (ctl.is_cur || found_ff);
   assign cand_out.entry = cand_ff.entry;
   assign rd_data        = rd_ff;
   assign count          = count_ff;

endmodule

// ===== hdl/detection_persistence_filter.sv =====
// Detection persistence filter: top level with frame ring control and result register.
//
// Detections of a frame are stored one per cycle, while the filter is idle, in the
// frame cell of the current slot; a frame end then runs the stability check and
// returns one or more result words. The cells form a row; each candidate of the
// current frame enters the row and moves one cell onward per phase, every cell but
// the current frame's scanning its own frame memory one entry per cycle during a
// phase. A frame end can be held up by stalls on the result side; before
// HISTORY_FRAMES frames have ended it skips the check and returns only the final
// word. The result register lets new words be taken while the last result still
// waits.
module detection_persistence_filter #(
   parameter int MAX_PER_FRAME  = dpf_pkg::DEF_MAX_PER_FRAME,
   parameter int HISTORY_FRAMES = dpf_pkg::DEF_HISTORY_FRAMES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dpf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dpf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dpf_pkg::LIMIT_BITS-1:0]    csr_wdata
);

   localparam int AW        = (MAX_PER_FRAME > 1) ? $clog2(MAX_PER_FRAME) : 1;
   localparam int CW        = $clog2(MAX_PER_FRAME + 1);
   localparam int PHASE_LEN = MAX_PER_FRAME + 4;
   localparam int TW        = $clog2(PHASE_LEN);
   localparam int PW        = $clog2(MAX_PER_FRAME + HISTORY_FRAMES + 1);
   localparam int SW        = $clog2(HISTORY_FRAMES);
   localparam int FW        = $clog2(HISTORY_FRAMES + 1);
   localparam int RW        = $clog2(dpf_pkg::MAX_RESULTS + 1);
   localparam int IW        = dpf_pkg::INDEX_BITS;
   localparam int LW        = 2 * dpf_pkg::LIMIT_BITS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type                     state_ff;
   logic [SW-1:0]                 cur_ff;
   logic [FW-1:0]                 seen_ff;
   logic                          ovf_ff;
   logic [dpf_pkg::LIMIT_BITS-1:0] lim_ff;
   logic [LW-1:0]                 lim2_ff;
   logic [TW-1:0]                 t_ff;
   logic [PW-1:0]                 ph_ff;
   logic [RW-1:0]                 res_cnt_ff;
   logic                          pend_valid_ff;
   dpf_pkg::entry_type            pend_ff;
   logic [IW-1:0]                 pend_idx_ff;
   dpf_pkg::rsp_type              rsp_ff;
   logic                          rsp_valid_ff;

   dpf_pkg::cand_type             chain_in  [0:HISTORY_FRAMES-1];
   dpf_pkg::cand_type             chain_out [0:HISTORY_FRAMES-1];
   dpf_pkg::entry_type            cell_rd   [0:HISTORY_FRAMES-1];
   logic [CW-1:0]                 cell_cnt  [0:HISTORY_FRAMES-1];
   dpf_pkg::cell_ctl_type         cell_ctl  [0:HISTORY_FRAMES-1];
   dpf_pkg::entry_type            wr_entry;

   logic            accept;
   logic            is_detect;
   logic [CW-1:0]   n_cur;
   logic [FW-1:0]   seen_in;
   logic [SW-1:0]   next_slot;
   logic            rsp_free;
   logic            phase_end;
   logic            do_shift;
   logic            last_phase;
   logic            advance;
   logic            tail_stable;
   logic            rsp_load;
   dpf_pkg::cand_type tail;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_detect = (req_data.opcode == dpf_pkg::OP_DETECT);
   assign csr_ready = 1'b1;

   assign n_cur     = cell_cnt[cur_ff];
   assign seen_in   = (seen_ff == FW'(HISTORY_FRAMES)) ? seen_ff : seen_ff + 1'b1;
   assign next_slot = (cur_ff == SW'(HISTORY_FRAMES - 1)) ? '0 : cur_ff + 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign phase_end = (state_ff == S_SCAN) && (t_ff == TW'(PHASE_LEN - 1));
   assign do_shift  = phase_end && rsp_free;
   assign last_phase = (ph_ff == PW'(n_cur) + PW'(HISTORY_FRAMES - 1));
   assign advance   = (state_ff == S_FINISH) && rsp_free;

   assign tail        = chain_out[HISTORY_FRAMES-1];
   assign tail_stable = tail.valid && tail.ok && (res_cnt_ff < RW'(dpf_pkg::MAX_RESULTS));
   assign rsp_load    = (do_shift && tail_stable && pend_valid_ff) || advance;

   assign wr_entry.color = req_data.color_class;
   assign wr_entry.x     = req_data.center_x;
   assign wr_entry.y     = req_data.center_y;

   // The feeder reads candidate number ph from the current frame's cell.
   assign chain_in[0].valid = (PW'(n_cur) > ph_ff);
   assign chain_in[0].ok    = 1'b1;
   assign chain_in[0].entry = cell_rd[cur_ff];

   for (genvar k = 0; k < HISTORY_FRAMES; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign chain_in[k] = chain_out[k-1];
      end
      assign cell_ctl[k].is_cur = (cur_ff == SW'(k));
      assign cell_ctl[k].wr_en  = accept && is_detect && (cur_ff == SW'(k));
      assign cell_ctl[k].clr    = advance && (next_slot == SW'(k));
      assign cell_ctl[k].shift  = do_shift;

      dpf_cell #(
         .MAX_PER_FRAME (MAX_PER_FRAME)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl[k]),
         .wr_data  (wr_entry),
         .phase_t  (t_ff),
         .rd_addr  (ph_ff[AW-1:0]),
         .lim2     (lim2_ff),
         .cand_in  (chain_in[k]),
         .cand_out (chain_out[k]),
         .rd_data  (cell_rd[k]),
         .count    (cell_cnt[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= dpf_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         lim_ff <= csr_wdata;
      end
      lim2_ff <= LW'(lim_ff) * LW'(lim_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         seen_ff       <= '0;
         ovf_ff        <= 1'b0;
         t_ff          <= '0;
         ph_ff         <= '0;
         res_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (is_detect) begin
                     if (n_cur == CW'(MAX_PER_FRAME)) begin
                        ovf_ff <= 1'b1;
                     end
                  end else begin
                     seen_ff       <= seen_in;
                     t_ff          <= '0;
                     ph_ff         <= '0;
                     res_cnt_ff    <= '0;
                     pend_valid_ff <= 1'b0;
                     state_ff      <= (seen_in == FW'(HISTORY_FRAMES)) ? S_SCAN : S_FINISH;
                  end
               end
            end
            S_SCAN: begin
               if (!phase_end) begin
                  t_ff <= t_ff + 1'b1;
               end else if (rsp_free) begin
                  t_ff  <= '0;
                  ph_ff <= ph_ff + 1'b1;
                  // A stable result is held back one step so the final one can carry last.
                  if (tail_stable) begin
                     res_cnt_ff    <= res_cnt_ff + 1'b1;
                     pend_valid_ff <= 1'b1;
                     pend_ff       <= tail.entry;
                     pend_idx_ff   <= res_cnt_ff[IW-1:0];
                     if (pend_valid_ff) begin
                        rsp_ff.valid_res      <= 1'b1;
                        rsp_ff.stable_index   <= pend_idx_ff;
                        rsp_ff.out_color      <= pend_ff.color;
                        rsp_ff.out_x          <= pend_ff.x;
                        rsp_ff.out_y          <= pend_ff.y;
                        rsp_ff.frame_overflow <= ovf_ff;
                        rsp_ff.last           <= 1'b0;
                     end
                  end
                  if (last_phase) begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_ff.valid_res      <= pend_valid_ff;
                  rsp_ff.stable_index   <= pend_valid_ff ? pend_idx_ff : '0;
                  rsp_ff.out_color      <= pend_valid_ff ? pend_ff.color : '0;
                  rsp_ff.out_x          <= pend_valid_ff ? pend_ff.x : '0;
                  rsp_ff.out_y          <= pend_valid_ff ? pend_ff.y : '0;
                  rsp_ff.frame_overflow <= ovf_ff;
                  rsp_ff.last           <= 1'b1;
                  cur_ff                <= next_slot;
                  ovf_ff                <= 1'b0;
                  pend_valid_ff         <= 1'b0;
                  state_ff              <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A word without a stable detection always closes its frame.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.valid_res) |-> rsp_data.last)
      else $error("empty result word without last");

   // A frame end always leaves the idle state for the check or the final word.
   a_frame_end_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_detect) |=> (state_ff != S_IDLE))
      else $error("frame end did not start result generation");

   // The current frame never holds more detections than the store has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_cur <= CW'(MAX_PER_FRAME))
      else $error("frame detection count out of range");

endmodule
